/* rtl/bgnc_pkg.sv */
package bgnc_pkg;

	localparam int ROW_BITS_W = 32;
	localparam int CFG_W = 6;
	localparam int COL_W = 5;
	localparam int CNT_W = 4;
	localparam int CSUM_W = 2;
	localparam logic [CFG_W-1:0] ROW_WIDTH_RESET = 6'd32;
	localparam logic [CNT_W-1:0] RULE_MIN = 4'd5;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} bgnc_state_t;

	typedef struct packed {
		logic accept;
		logic last;
		logic have_prior;
		logic load_first;
		logic load_single;
		logic load_second;
		logic step;
	} bgnc_ctl_t;

endpackage

/* rtl/bgnc_ctrl.sv */
module bgnc_ctrl #(
	parameter int MAX_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          last_row,
	output logic                          out_valid,
	input  logic                          out_stall,
	input  logic [$clog2(MAX_WIDTH)-1:0]  wlast,
	output bgnc_pkg::bgnc_ctl_t           ctl,
	output logic [bgnc_pkg::COL_W-1:0]    column,
	output logic                          last_of_run,
	output logic                          frame_done
);
	import bgnc_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);

	bgnc_state_t   state_q, state_d;
	logic [CW-1:0] col_q;
	logic          second_q;
	logic          frame_q;
	logic          have_prior_q;
	logic          out_valid_q;
	logic [COL_W-1:0] column_q;
	logic          last_of_run_q;
	logic          frame_done_q;
	logic          last_col;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (ctl.accept && (have_prior_q || last_row)) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (ctl.step && last_col && !second_q) begin
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	always_comb begin
		last_col        = (col_q == wlast);
		in_stall        = (state_q != ST_IDLE);
		ctl.accept      = in_valid && (state_q == ST_IDLE);
		ctl.last        = last_row;
		ctl.have_prior  = have_prior_q;
		ctl.step        = (state_q == ST_RUN) && (!out_valid_q || !out_stall);
		ctl.load_first  = ctl.accept && have_prior_q;
		ctl.load_single = ctl.accept && !have_prior_q && last_row;
		ctl.load_second = ctl.step && last_col && second_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			col_q        <= '0;
			second_q     <= 1'b0;
			frame_q      <= 1'b0;
			have_prior_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.accept) begin
				col_q        <= '0;
				second_q     <= have_prior_q && last_row;
				frame_q      <= !have_prior_q && last_row;
				have_prior_q <= !last_row;
			end else if (ctl.load_second) begin
				col_q    <= '0;
				second_q <= 1'b0;
				frame_q  <= 1'b1;
			end else if (ctl.step && !last_col) begin
				col_q <= col_q + CW'(1);
			end
			if (ctl.step) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result side fields
	always_ff @(posedge clk) begin
		if (ctl.step) begin
			column_q      <= COL_W'(col_q);
			last_of_run_q <= last_col && !second_q;
			frame_done_q  <= last_col && frame_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign column      = column_q;
	assign last_of_run = last_of_run_q;
	assign frame_done  = frame_done_q;

	a_first_row_silent: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.accept && !have_prior_q && !last_row |=> state_q == ST_IDLE)
		else $error("first row of frame started a run");

	a_second_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		second_q |-> state_q == ST_RUN)
		else $error("second row pending outside a run");

	a_frame_pass_clean: assert property (@(posedge clk) disable iff (!arst_n)
		frame_q && state_q == ST_RUN |-> !have_prior_q)
		else $error("bottom row pass with stored row still marked");

	a_step_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.step |=> out_valid_q)
		else $error("column step produced no result");

	a_accept_col_zero: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.accept |=> col_q == '0)
		else $error("column counter not cleared on transfer");

endmodule

/* rtl/bgnc_window.sv */
module bgnc_window #(
	parameter int MAX_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bgnc_pkg::bgnc_ctl_t           ctl,
	input  logic [MAX_WIDTH-1:0]          row,
	input  logic [$clog2(MAX_WIDTH)-1:0]  wlast,
	output logic [bgnc_pkg::CNT_W-1:0]    neighbor_count,
	output logic                          rule_bit,
	output logic [bgnc_pkg::CNT_W-1:0]    hint_count
);
	import bgnc_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);

	logic [MAX_WIDTH-1:0] row_two_back_q, row_one_back_q;
	logic [MAX_WIDTH-1:0] above2_q, row_in_q;
	logic [MAX_WIDTH-1:0] sh_a_q, sh_c_q, sh_b_q;
	logic [MAX_WIDTH-1:0] mask, src_a, src_b, src_c, am, cm, bm;
	logic [CSUM_W-1:0]    cs_prev_q, cs_cur_q, cs_next, cs_load;
	logic                 centre_q;
	logic [CNT_W-1:0]     cnt;
	logic [CNT_W-1:0]     count_q, hint_q;
	logic                 rule_q;
	logic                 load;

	always_comb begin
		for (int j = 0; j < MAX_WIDTH; j++) begin
			mask[j] = (CW'(j) <= wlast);
		end
	end

	always_comb begin
		priority if (ctl.load_first) begin
			src_a = row_two_back_q;
			src_c = row_one_back_q;
			src_b = row;
		end else if (ctl.load_single) begin
			src_a = '0;
			src_c = row;
			src_b = '0;
		end else begin
			src_a = above2_q;
			src_c = row_in_q;
			src_b = '0;
		end
		load    = ctl.load_first || ctl.load_single || ctl.load_second;
		am      = src_a & mask;
		cm      = src_c & mask;
		bm      = src_b & mask;
		cs_load = CSUM_W'(am[0]) + CSUM_W'(cm[0]) + CSUM_W'(bm[0]);
		cs_next = CSUM_W'(sh_a_q[0]) + CSUM_W'(sh_c_q[0]) + CSUM_W'(sh_b_q[0]);
		cnt     = CNT_W'(cs_prev_q) + CNT_W'(cs_cur_q) + CNT_W'(cs_next);
	end

	// rows kept across items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_two_back_q <= '0;
			row_one_back_q <= '0;
		end else if (ctl.accept) begin
			if (ctl.last) begin
				row_two_back_q <= '0;
				row_one_back_q <= '0;
			end else begin
				row_two_back_q <= ctl.have_prior ? row_one_back_q : '0;
				row_one_back_q <= row;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			row_in_q <= row;
			above2_q <= ctl.have_prior ? row_one_back_q : '0;
		end
		if (load) begin
			sh_a_q    <= am >> 1;
			sh_c_q    <= cm >> 1;
			sh_b_q    <= bm >> 1;
			cs_prev_q <= '0;
			cs_cur_q  <= cs_load;
			centre_q  <= cm[0];
		end else if (ctl.step) begin
			sh_a_q    <= sh_a_q >> 1;
			sh_c_q    <= sh_c_q >> 1;
			sh_b_q    <= sh_b_q >> 1;
			cs_prev_q <= cs_cur_q;
			cs_cur_q  <= cs_next;
			centre_q  <= sh_c_q[0];
		end
		if (ctl.step) begin
			count_q <= cnt;
			rule_q  <= (cnt == '0) || (cnt >= RULE_MIN);
			hint_q  <= centre_q ? '0 : cnt;
		end
	end

	assign neighbor_count = count_q;
	assign rule_bit       = rule_q;
	assign hint_count     = hint_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.step |=> count_q <= CNT_W'(9))
		else $error("window count above nine");

	a_hint_zero_on_set: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.step && centre_q |=> hint_q == '0)
		else $error("hint not cleared for set centre");

	a_load_clears_prev: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> cs_prev_q == '0)
		else $error("left column sum not cleared at row start");

endmodule

/* rtl/binary_grid_neighbor_count.sv */
// channel | direction | handshake        | payload
// cfg     | in        | cfg_valid/ready  | cfg_data (row_width)
// in      | in        | in_valid/stall   | row_bits, last_row
// out     | out       | out_valid/stall  | column, neighbor_count, rule_bit,
//         |           |                  | hint_count, last_of_run, frame_done
//
// an item is taken in one transfer and then causes none, one or two rows of
// results, each with one column step per column of width w; stall holds the steps.
// the row shift registers move one column a cycle unless out_stall holds a pending result.
// reset clears stored rows and sets row_width to 32; no clearing pass.
// out_stall holds the column sequencer; in_stall is high while a run of results is in progress.
module binary_grid_neighbor_count #(
	parameter int MAX_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bgnc_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [bgnc_pkg::ROW_BITS_W-1:0]     row_bits,
	input  logic                                last_row,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [bgnc_pkg::COL_W-1:0]          column,
	output logic [bgnc_pkg::CNT_W-1:0]          neighbor_count,
	output logic                                rule_bit,
	output logic [bgnc_pkg::CNT_W-1:0]          hint_count,
	output logic                                last_of_run,
	output logic                                frame_done
);
	import bgnc_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam logic [CFG_W-1:0] MAX_W_C = CFG_W'(MAX_WIDTH);

	logic [CFG_W-1:0]     row_width_q;
	logic [CW-1:0]        wlast;
	logic [MAX_WIDTH-1:0] row;
	bgnc_ctl_t            ctl;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= ROW_WIDTH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			row_width_q <= cfg_data;
		end
	end

	// index of the last column in use
	always_comb begin
		priority if (row_width_q == '0) begin
			wlast = '0;
		end else if (row_width_q > MAX_W_C) begin
			wlast = CW'(MAX_WIDTH - 1);
		end else begin
			wlast = CW'(row_width_q - CFG_W'(1));
		end
	end

	assign row = row_bits[MAX_WIDTH-1:0];

	bgnc_ctrl #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.last_row   (last_row),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.wlast      (wlast),
		.ctl        (ctl),
		.column     (column),
		.last_of_run(last_of_run),
		.frame_done (frame_done)
	);

	bgnc_window #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_window (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.row           (row),
		.wlast         (wlast),
		.neighbor_count(neighbor_count),
		.rule_bit      (rule_bit),
		.hint_count    (hint_count)
	);

	a_no_transfer_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.step |-> !ctl.accept)
		else $error("input transfer during column run");

	a_cfg_taken: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |=> row_width_q == $past(cfg_data))
		else $error("row width write lost");

	a_wlast_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(wlast) <= MAX_WIDTH - 1)
		else $error("last column beyond storage");

endmodule
